[sv/prime_field_alu_assert.svh]
// Assertion macros for the prime field ALU.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef PRIME_FIELD_ALU_ASSERT_SVH
`define PRIME_FIELD_ALU_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PFA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("pfa assertion failed");

// Next-cycle implication, disabled during reset.
`define PFA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("pfa assertion failed");

`endif

[sv/pfa_pkg.sv]
// Shared widths, field constants and command codes of the prime field ALU.
// No dependencies; used by the channel interfaces and the top level.
package pfa_pkg;

  localparam int CMD_W = 4;
  localparam int OPD_W = 22;
  localparam int RES_W = 21;

  // Field modulus, its double for the reduction steps, and M-1 and M-2 for the exponents.
  localparam logic [RES_W-1:0] MOD    = 21'd1234577;
  localparam logic [RES_W:0]   MOD_X2 = 22'd2469154;
  localparam logic [RES_W-1:0] MOD_M1 = 21'd1234576;
  localparam logic [RES_W-1:0] MOD_M2 = 21'd1234575;

  localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
  localparam logic [CMD_W-1:0] CMD_POW = 4'd4;
  localparam logic [CMD_W-1:0] CMD_EQ  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_LT  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_GT  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_LE  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_GE  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_NE  = 4'd10;

endpackage

[sv/pfa_if.sv]
// Valid/ready channel interfaces of the prime field ALU: request and response.
// Depends on pfa_pkg for field widths.
interface pfa_req_if import pfa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [OPD_W-1:0] operand_a;
  logic signed [OPD_W-1:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] value;
  logic             truth;
  logic             no_inverse;

  modport source (output valid, value, truth, no_inverse, input ready);
  modport sink   (input valid, value, truth, no_inverse, output ready);
endinterface

[sv/prime_field_alu.sv]
// Prime field ALU: add, sub, mul, div, pow and six residue comparisons mod 1234577.
// Depends on pfa_pkg, the pfa_req_if / pfa_rsp_if interfaces and the assertion header.
//
// Usage:
//   req carries command, operand_a, operand_b; rsp returns value, truth, no_inverse.
//   A transfer happens on a rising edge with valid and ready both high.
//   One item is in flight at a time: req.ready is high only while the block idles.
//   A request passes S_EXEC, any S_MUL products and S_DONE before rsp.valid; per command:
//     add, sub, comparisons, unused codes : computed in S_EXEC
//     mul                                 : one product on the multiplier
//     pow                                 : square-and-multiply; e that gives 1 ends in S_EXEC
//     div                                 : Fermat inverse b^(M-2), then one mul; b = 0 flags no_inverse
//   req.ready rises with rsp.valid, so no new request is taken before the last
//   result has been loaded into the output register.
//   All products go through one shift-add modular multiplier that retires one
//   multiplier bit per cycle; pow and div run square-and-multiply over 21 exponent
//   bits on that unit, so it sets the rate.
//   Reset clears the sequencer and drops any pending result.
//   When the receiver stalls, the result holds in the output register; the next
//   request is taken meanwhile and its result waits until the register frees up.
`include "prime_field_alu_assert.svh"

module prime_field_alu import pfa_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  pfa_req_if.sink   req,
  pfa_rsp_if.source rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  localparam logic [1:0] PH_SQR   = 2'd0;  // square the running power
  localparam logic [1:0] PH_MULB  = 2'd1;  // multiply by the base
  localparam logic [1:0] PH_FINAL = 2'd2;  // last product, goes to the result

  localparam logic [4:0] MUL_LAST = 5'(RES_W - 1);
  localparam logic [4:0] BIT_TOP  = 5'(RES_W - 1);

  // Sequencer and operand registers.
  logic [2:0]       state;
  logic [1:0]       phase;
  logic [CMD_W-1:0] cmd;
  logic [RES_W-1:0] a_res;
  logic [RES_W-1:0] b_res;
  logic [RES_W-1:0] exp_r;
  logic             exp_zero;
  logic [4:0]       bidx;

  // Shared shift-add multiplier: mr accumulates mx * my mod M, MSB of my first.
  logic [RES_W-1:0] mx;
  logic [RES_W-1:0] my;
  logic [RES_W-1:0] mr;
  logic [4:0]       mcnt;

  // Pending result and output register.
  logic [RES_W-1:0] res_value;
  logic             res_truth;
  logic             res_noinv;
  logic             out_valid;
  logic [RES_W-1:0] out_value;
  logic             out_truth;
  logic             out_noinv;

  // Combinational helpers.
  logic [RES_W-1:0] a_norm;
  logic [RES_W-1:0] b_norm;
  logic [RES_W:0]   a_pos;
  logic [RES_W:0]   b_pos;
  logic [OPD_W:0]   a_p1, a_p2, b_p1, b_p2;
  logic [OPD_W:0]   e_neg;
  logic [RES_W-1:0] exp_in;
  logic             exp_zero_in;
  logic [RES_W:0]   sum_ab;
  logic [RES_W:0]   dif_ab;
  logic [RES_W-1:0] add_val;
  logic [RES_W-1:0] sub_val;
  logic [RES_W:0]   step_t;
  logic [RES_W-1:0] step_r;
  logic [RES_W-1:0] base;

  // Bring each signed operand to its residue: a negative one gets M added,
  // and 2M when that is still negative; a positive one loses M at most once.
  always_comb begin
    a_pos = {1'b0, req.operand_a[RES_W-1:0]};
    b_pos = {1'b0, req.operand_b[RES_W-1:0]};
    a_p1  = {req.operand_a[OPD_W-1], req.operand_a} + {2'b00, MOD};
    a_p2  = {req.operand_a[OPD_W-1], req.operand_a} + {1'b0, MOD_X2};
    b_p1  = {req.operand_b[OPD_W-1], req.operand_b} + {2'b00, MOD};
    b_p2  = {req.operand_b[OPD_W-1], req.operand_b} + {1'b0, MOD_X2};
    if (!req.operand_a[OPD_W-1]) begin
      a_norm = (a_pos >= {1'b0, MOD}) ? RES_W'(a_pos - {1'b0, MOD}) : a_pos[RES_W-1:0];
    end else begin
      a_norm = a_p1[OPD_W] ? a_p2[RES_W-1:0] : a_p1[RES_W-1:0];
    end
    if (!req.operand_b[OPD_W-1]) begin
      b_norm = (b_pos >= {1'b0, MOD}) ? RES_W'(b_pos - {1'b0, MOD}) : b_pos[RES_W-1:0];
    end else begin
      b_norm = b_p1[OPD_W] ? b_p2[RES_W-1:0] : b_p1[RES_W-1:0];
    end
  end

  // Exponent: negative e becomes M-1+e with no reduction; e = 0, or M-1+e zero or below, gives 1.
  always_comb begin
    e_neg = {req.operand_b[OPD_W-1], req.operand_b} + {2'b00, MOD_M1};
    if (req.operand_b[OPD_W-1]) begin
      exp_in      = e_neg[RES_W-1:0];
      exp_zero_in = e_neg[OPD_W] || (e_neg == '0);
    end else begin
      exp_in      = req.operand_b[RES_W-1:0];
      exp_zero_in = (req.operand_b == '0);
    end
  end

  // Combinational field add and subtract.
  always_comb begin
    sum_ab  = {1'b0, a_res} + {1'b0, b_res};
    dif_ab  = {1'b0, a_res} - {1'b0, b_res};
    add_val = (sum_ab >= {1'b0, MOD}) ? RES_W'(sum_ab - {1'b0, MOD}) : sum_ab[RES_W-1:0];
    sub_val = dif_ab[RES_W] ? RES_W'(dif_ab + {1'b0, MOD}) : dif_ab[RES_W-1:0];
  end

  // One multiplier step: double, add mx on a set bit, fold back below M.
  always_comb begin
    step_t = {mr, 1'b0} + (my[RES_W-1] ? {1'b0, mx} : '0);
    if (step_t >= MOD_X2) begin
      step_r = RES_W'(step_t - MOD_X2);
    end else if (step_t >= {1'b0, MOD}) begin
      step_r = RES_W'(step_t - {1'b0, MOD});
    end else begin
      step_r = step_t[RES_W-1:0];
    end
  end

  // div raises the divisor to M-2; pow raises the first operand.
  assign base = (cmd == CMD_DIV) ? b_res : a_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mcnt      <= '0;
    end else begin
      // Drop the output once taken; a fresh load below overrides.
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd      <= req.command;
            a_res    <= a_norm;
            b_res    <= b_norm;
            exp_r    <= exp_in;
            exp_zero <= exp_zero_in;
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_value <= '0;
          res_truth <= 1'b0;
          res_noinv <= 1'b0;
          state     <= S_DONE;
          mr        <= '0;
          mcnt      <= '0;
          case (cmd)
            CMD_ADD: res_value <= add_val;
            CMD_SUB: res_value <= sub_val;
            CMD_MUL: begin
              mx    <= a_res;
              my    <= b_res;
              phase <= PH_FINAL;
              state <= S_MUL;
            end
            CMD_DIV: begin
              // Prime modulus: only zero lacks an inverse.
              if (b_res == '0) begin
                res_noinv <= 1'b1;
              end else begin
                exp_r <= MOD_M2;
                bidx  <= BIT_TOP;
                mx    <= RES_W'(1);
                my    <= RES_W'(1);
                phase <= PH_SQR;
                state <= S_MUL;
              end
            end
            CMD_POW: begin
              if (exp_zero) begin
                res_value <= RES_W'(1);
              end else begin
                bidx  <= BIT_TOP;
                mx    <= RES_W'(1);
                my    <= RES_W'(1);
                phase <= PH_SQR;
                state <= S_MUL;
              end
            end
            CMD_EQ:  res_truth <= (a_res == b_res);
            CMD_LT:  res_truth <= (a_res <  b_res);
            CMD_GT:  res_truth <= (a_res >  b_res);
            CMD_LE:  res_truth <= (a_res <= b_res);
            CMD_GE:  res_truth <= (a_res >= b_res);
            CMD_NE:  res_truth <= (a_res != b_res);
            default: res_value <= '0;
          endcase
        end

        S_MUL: begin
          mr   <= step_r;
          my   <= {my[RES_W-2:0], 1'b0};
          mcnt <= mcnt + 5'd1;
          if (mcnt == MUL_LAST) begin
            mr   <= '0;
            mcnt <= '0;
            if (phase == PH_FINAL) begin
              res_value <= step_r;
              state     <= S_DONE;
            end else if (phase == PH_SQR && exp_r[bidx]) begin
              mx    <= step_r;
              my    <= base;
              phase <= PH_MULB;
            end else if (bidx == '0) begin
              // Power complete: deliver it, or multiply the inverse by a for div.
              if (cmd == CMD_DIV) begin
                mx    <= step_r;
                my    <= a_res;
                phase <= PH_FINAL;
              end else begin
                res_value <= step_r;
                state     <= S_DONE;
              end
            end else begin
              bidx  <= bidx - 5'd1;
              mx    <= step_r;
              my    <= step_r;
              phase <= PH_SQR;
            end
          end
        end

        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_value <= res_value;
            out_truth <= res_truth;
            out_noinv <= res_noinv;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.value      = out_value;
  assign rsp.truth      = out_truth;
  assign rsp.no_inverse = out_noinv;

  `PFA_ASSERT_NXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)
  `PFA_ASSERT_IMP(a_mul_acc_reduced, clk, rst, state == S_MUL, mr < MOD)
  `PFA_ASSERT_IMP(a_noinv_clean, clk, rst, rsp.valid && rsp.no_inverse, rsp.value == '0 && !rsp.truth)
  `PFA_ASSERT_IMP(a_truth_clean, clk, rst, rsp.valid && rsp.truth, rsp.value == '0 && !rsp.no_inverse)

endmodule
